### design/dnps_pkg.sv
`default_nettype none

package dnps_pkg;

    // default table depth
    localparam int MAX_PANES_DEF = 64;

    // field widths
    localparam int COUNT_W  = 7;
    localparam int SLOT_W   = 6;
    localparam int ID_W     = 16;
    localparam int COORD_W  = 16;
    localparam int SIZE_W   = 15;
    localparam int CTR_W    = COORD_W + 1;
    localparam int DIFF_W   = CTR_W + 1;
    localparam int METRIC_W = DIFF_W + 1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_FOCUS = 2'd1,
        OP_MOVE  = 2'd2,
        OP_CYCLE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_NO_CAND   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SCAN,
        S_PICK,
        S_PICK_WAIT,
        S_RESULT
    } state_t;

    // one table entry, centres worked out when the entry is written
    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [CTR_W-1:0] cx;
        logic signed [CTR_W-1:0] cy;
    } entry_t;

    typedef struct packed {
        logic signed [CTR_W-1:0] cx;
        logic signed [CTR_W-1:0] cy;
    } center_t;

    // control towards the scan unit
    typedef struct packed {
        logic start;
        logic vld;
        logic skip;
        logic last;
        dir_t dir;
    } scan_ctl_t;

    // outcome of a scan
    typedef struct packed {
        logic            done;
        logic            found;
        logic [ID_W-1:0] id;
    } scan_res_t;

    // left + width/2, halving by truncation
    function automatic logic signed [CTR_W-1:0] center(
        input logic signed [COORD_W-1:0] pos_v,
        input logic [SIZE_W-1:0]         size_v
    );
        return $signed({pos_v[COORD_W-1], pos_v})
             + $signed({{(CTR_W-SIZE_W+1){1'b0}}, size_v[SIZE_W-1:1]});
    endfunction

endpackage

`default_nettype wire

### design/dnps_if.sv
`default_nettype none

// request channel
interface dnps_req_if
    import dnps_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic [SLOT_W-1:0]         entry_index;
    logic [ID_W-1:0]           pane_id;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic [SIZE_W-1:0]         width;
    logic [SIZE_W-1:0]         height;
    logic [1:0]                direction;
    logic                      forward;

    modport source (
        output valid, opcode, entry_index, pane_id, left, top, width, height,
               direction, forward,
        input  ready
    );
    modport sink (
        input  valid, opcode, entry_index, pane_id, left, top, width, height,
               direction, forward,
        output ready
    );
endinterface

// response channel
interface dnps_rsp_if
    import dnps_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [1:0]      status;
    logic [ID_W-1:0] focused_pane;

    modport source (output valid, status, focused_pane, input ready);
    modport sink (input valid, status, focused_pane, output ready);
endinterface

// pane count write channel
interface dnps_cfg_if
    import dnps_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

### design/dnps_scan_unit.sv
`default_nettype none

module dnps_scan_unit
    import dnps_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire scan_ctl_t ctl,
    input  wire entry_t    ent,
    input  wire center_t   ctr,
    output scan_res_t      res
);

    // stage 1: differences
    logic                     s1_vld_reg;
    logic                     s1_skip_reg;
    logic                     s1_last_reg;
    logic [ID_W-1:0]          s1_id_reg;
    logic signed [DIFF_W-1:0] s1_prim_reg;
    logic signed [DIFF_W-1:0] s1_orth_p_reg;
    logic signed [DIFF_W-1:0] s1_orth_n_reg;
    logic signed [DIFF_W-1:0] s1_prim_next;
    logic signed [DIFF_W-1:0] s1_orth_p_next;
    logic signed [DIFF_W-1:0] s1_orth_n_next;

    // stage 2: metric
    logic                s2_vld_reg;
    logic                s2_ok_reg;
    logic                s2_last_reg;
    logic [ID_W-1:0]     s2_id_reg;
    logic [METRIC_W-1:0] s2_metric_reg;
    logic                s2_ok_next;
    logic [METRIC_W-1:0] s2_metric_next;
    logic [DIFF_W-1:0]   orth_abs;

    // best so far
    logic                best_vld_reg;
    logic [METRIC_W-1:0] low_metric_reg;
    logic [ID_W-1:0]     best_id_reg;
    logic                take;

    logic signed [DIFF_W-1:0] dx_p, dx_n, dy_p, dy_n;

    always_comb
    begin
        dx_p = $signed({ent.cx[CTR_W-1], ent.cx}) - $signed({ctr.cx[CTR_W-1], ctr.cx});
        dx_n = $signed({ctr.cx[CTR_W-1], ctr.cx}) - $signed({ent.cx[CTR_W-1], ent.cx});
        dy_p = $signed({ent.cy[CTR_W-1], ent.cy}) - $signed({ctr.cy[CTR_W-1], ctr.cy});
        dy_n = $signed({ctr.cy[CTR_W-1], ctr.cy}) - $signed({ent.cy[CTR_W-1], ent.cy});
        case (ctl.dir)
            DIR_LEFT:
            begin
                s1_prim_next = dx_n; s1_orth_p_next = dy_p; s1_orth_n_next = dy_n;
            end
            DIR_RIGHT:
            begin
                s1_prim_next = dx_p; s1_orth_p_next = dy_p; s1_orth_n_next = dy_n;
            end
            DIR_UP:
            begin
                s1_prim_next = dy_n; s1_orth_p_next = dx_p; s1_orth_n_next = dx_n;
            end
            default:
            begin
                s1_prim_next = dy_p; s1_orth_p_next = dx_p; s1_orth_n_next = dx_n;
            end
        endcase
    end

    always_comb
    begin
        orth_abs = s1_orth_p_reg[DIFF_W-1] ? s1_orth_n_reg : s1_orth_p_reg;
        // strictly on the requested side, current pane excluded
        s2_ok_next = !s1_skip_reg && !s1_prim_reg[DIFF_W-1] && (s1_prim_reg != '0);
        s2_metric_next = {1'b0, s1_prim_reg} + {orth_abs, 1'b0};
    end

    // strict less keeps the lowest index on a tie
    assign take = s2_vld_reg && s2_ok_reg
                  && (!best_vld_reg || (s2_metric_reg < low_metric_reg));

    always_comb
    begin
        res.done  = s2_vld_reg && s2_last_reg;
        res.found = best_vld_reg || take;
        res.id    = take ? s2_id_reg : best_id_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= ctl.vld;
            s2_vld_reg <= s1_vld_reg;
            if (take)
                best_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_skip_reg   <= ctl.skip;
        s1_last_reg   <= ctl.last;
        s1_id_reg     <= ent.id;
        s1_prim_reg   <= s1_prim_next;
        s1_orth_p_reg <= s1_orth_p_next;
        s1_orth_n_reg <= s1_orth_n_next;
        s2_ok_reg     <= s2_ok_next;
        s2_last_reg   <= s1_last_reg;
        s2_id_reg     <= s1_id_reg;
        s2_metric_reg <= s2_metric_next;
        if (take)
        begin
            low_metric_reg <= s2_metric_reg;
            best_id_reg    <= s2_id_reg;
        end
    end

endmodule

`default_nettype wire

### design/directional_nearest_pane_select_core.sv
`default_nettype none

// channel   role    moves
// ------    ----    -----
// cfg       sink    pane count write, always ready
// req       sink    one request: write entry, set focus, move or cycle
// rsp       source  status and focused pane id, one per request
//
// write entry and set focus go to the response register without a walk; a
// cycle or a move first walks the table once, up to the pane count capped at
// MAX_PANES, to find the focused pane, one entry per cycle from the single
// read port of the table; a move then walks it again through the pipelined
// scan unit.
// reset clears focus, pane count and control; table contents stay undefined.
// a finished response waits in the output register; the next request is
// taken meanwhile but its own response stalls until that register frees.

module directional_nearest_pane_select_core
    import dnps_pkg::*;
#(
    parameter int MAX_PANES = MAX_PANES_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dnps_cfg_if.sink    cfg,
    dnps_req_if.sink    req,
    dnps_rsp_if.source  rsp
);

    localparam int IW = $clog2(MAX_PANES);       // table index
    localparam int CW = $clog2(MAX_PANES + 1);   // count up to MAX_PANES

    // pane table, single write port and registered read
    entry_t  mem [MAX_PANES];
    entry_t  rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic    wr_en;
    logic [IW-1:0] wr_addr;
    entry_t  wr_ent;

    // control and working registers
    logic [COUNT_W-1:0] pane_count_reg;
    state_t  state_reg, state_next;
    logic [ID_W-1:0] focus_reg, focus_next;
    status_t status_reg, status_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] iss_reg, iss_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] pick_reg, pick_next;
    center_t ctr_reg, ctr_next;
    logic    move_reg, move_next;
    dir_t    dir_reg, dir_next;
    logic    fwd_reg, fwd_next;
    logic    s0_vld_reg, s0_vld_next;
    logic [IW-1:0] s0_tag_reg, s0_tag_next;

    // response register
    logic            rsp_vld_reg;
    status_t         rsp_status_reg;
    logic [ID_W-1:0] rsp_focus_reg;
    logic            load_rsp;

    logic      req_acc;
    op_t       req_op;
    logic [CW-1:0] cnt_live;
    logic      issue;
    logic      match;
    logic      last_tag;
    logic      scan_start;
    scan_ctl_t scan_ctl;
    scan_res_t scan_res;
    logic [IW-1:0] nxt_idx;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign req_op    = op_t'(req.opcode);

    // count saturated to the table size
    assign cnt_live = (32'(pane_count_reg) > MAX_PANES) ? CW'(MAX_PANES)
                                                        : CW'(pane_count_reg);

    // table write, slots beyond the table are dropped
    assign wr_en     = req_acc && (req_op == OP_WRITE) && (32'(req.entry_index) < MAX_PANES);
    assign wr_addr   = IW'(req.entry_index);
    assign wr_ent.id = req.pane_id;
    assign wr_ent.cx = center(req.left, req.width);
    assign wr_ent.cy = center(req.top, req.height);

    assign rd_addr = (state_reg == S_PICK) ? pick_reg : iss_reg[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_ent;
        rd_data_reg <= mem[rd_addr];
    end

    // stage 0 flags on the entry just read
    assign match    = s0_vld_reg && (rd_data_reg.id == focus_reg);
    assign last_tag = (CW'(s0_tag_reg) == (cnt_reg - CW'(1)));

    // neighbour index for a cycle, wrapping over the count
    always_comb
    begin
        if (fwd_reg)
            nxt_idx = ((CW'(s0_tag_reg) + CW'(1)) == cnt_reg) ? '0 : s0_tag_reg + IW'(1);
        else
            nxt_idx = (s0_tag_reg == '0) ? IW'(cnt_reg - CW'(1)) : s0_tag_reg - IW'(1);
    end

    assign issue = (iss_reg < cnt_reg);

    always_comb
    begin
        state_next  = state_reg;
        focus_next  = focus_reg;
        status_next = status_reg;
        cnt_next    = cnt_reg;
        iss_next    = iss_reg;
        cur_next    = cur_reg;
        pick_next   = pick_reg;
        ctr_next    = ctr_reg;
        move_next   = move_reg;
        dir_next    = dir_reg;
        fwd_next    = fwd_reg;
        s0_vld_next = 1'b0;
        s0_tag_next = iss_reg[IW-1:0];
        scan_start  = 1'b0;
        load_rsp    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    status_next = STAT_OK;
                    case (req_op)
                        OP_WRITE:
                        begin
                            state_next = S_RESULT;
                        end
                        OP_FOCUS:
                        begin
                            focus_next = req.pane_id;
                            state_next = S_RESULT;
                        end
                        default:
                        begin
                            move_next = (req_op == OP_MOVE);
                            dir_next  = dir_t'(req.direction);
                            fwd_next  = req.forward;
                            cnt_next  = cnt_live;
                            iss_next  = '0;
                            if (cnt_live == '0)
                            begin
                                status_next = STAT_EMPTY;
                                state_next  = S_RESULT;
                            end
                            else
                                state_next = S_FIND;
                        end
                    endcase
                end
            end

            S_FIND:
            begin
                if (match)
                begin
                    // lowest index holding the focused id
                    cur_next    = s0_tag_reg;
                    ctr_next.cx = rd_data_reg.cx;
                    ctr_next.cy = rd_data_reg.cy;
                    iss_next    = '0;
                    if (move_reg)
                    begin
                        scan_start = 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        pick_next  = nxt_idx;
                        state_next = S_PICK;
                    end
                end
                else if (s0_vld_reg && last_tag)
                begin
                    status_next = STAT_NOT_FOUND;
                    state_next  = S_RESULT;
                end
                else if (issue)
                begin
                    s0_vld_next = 1'b1;
                    iss_next    = iss_reg + CW'(1);
                end
            end

            S_SCAN:
            begin
                if (issue)
                begin
                    s0_vld_next = 1'b1;
                    iss_next    = iss_reg + CW'(1);
                end
                if (scan_res.done)
                begin
                    if (scan_res.found)
                    begin
                        focus_next  = scan_res.id;
                        status_next = STAT_OK;
                    end
                    else
                        status_next = STAT_NO_CAND;
                    state_next = S_RESULT;
                end
            end

            S_PICK:
            begin
                state_next = S_PICK_WAIT;
            end

            S_PICK_WAIT:
            begin
                focus_next  = rd_data_reg.id;
                status_next = STAT_OK;
                state_next  = S_RESULT;
            end

            S_RESULT:
            begin
                if (!rsp_vld_reg || rsp.ready)
                begin
                    load_rsp   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // scan unit fed straight from the table read register
    always_comb
    begin
        scan_ctl.start = scan_start;
        scan_ctl.vld   = s0_vld_reg && (state_reg == S_SCAN);
        scan_ctl.skip  = (s0_tag_reg == cur_reg);
        scan_ctl.last  = last_tag;
        scan_ctl.dir   = dir_reg;
    end

    dnps_scan_unit u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .ent   (rd_data_reg),
        .ctr   (ctr_reg),
        .res   (scan_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            focus_reg      <= '0;
            pane_count_reg <= '0;
            s0_vld_reg     <= 1'b0;
            rsp_vld_reg    <= 1'b0;
            iss_reg        <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            focus_reg  <= focus_next;
            s0_vld_reg <= s0_vld_next;
            iss_reg    <= iss_next;
            cnt_reg    <= cnt_next;
            if (cfg.valid && cfg.ready)
                pane_count_reg <= cfg.data;
            if (load_rsp)
                rsp_vld_reg <= 1'b1;
            else if (rsp.ready)
                rsp_vld_reg <= 1'b0;
        end
    end

    // working payload, no reset needed
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        cur_reg    <= cur_next;
        pick_reg   <= pick_next;
        ctr_reg    <= ctr_next;
        move_reg   <= move_next;
        dir_reg    <= dir_next;
        fwd_reg    <= fwd_next;
        s0_tag_reg <= s0_tag_next;
        if (load_rsp)
        begin
            rsp_status_reg <= status_reg;
            rsp_focus_reg  <= focus_reg;
        end
    end

    assign rsp.valid        = rsp_vld_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.focused_pane = rsp_focus_reg;

    // an empty table answers at once without a walk
    a_empty_short: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && (req_op == OP_MOVE || req_op == OP_CYCLE) && cnt_live == '0)
        |=> (state_reg == S_RESULT && status_reg == STAT_EMPTY))
        else $error("empty table did not answer directly");

    // the read pointer never passes the count while walking
    a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND || state_reg == S_SCAN) |-> (iss_reg <= cnt_reg))
        else $error("table read pointer beyond pane count");

    // scan completion only while scanning
    a_done_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_res.done |-> (state_reg == S_SCAN))
        else $error("scan unit finished outside a scan");

    // focus only changes on the way into the response state
    a_focus_chg: assert property (@(posedge clk) disable iff (!rst_n)
        (focus_reg != $past(focus_reg)) |-> (state_reg == S_RESULT))
        else $error("focus changed outside a response");

endmodule

`default_nettype wire

### sim/directional_nearest_pane_select_core_checker.sv
`default_nettype none

// watches the three channels, keeps its own copy of the pane table and focus,
// and compares every response with the oldest predicted outcome
module pane_select_checker
    import dnps_pkg::*;
#(
    parameter int MAX_PANES = MAX_PANES_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    dnps_cfg_if       cfg,
    dnps_req_if       req,
    dnps_rsp_if       rsp,
    output int        pending,
    output int        fail_count
);

    typedef struct {
        status_t         status;
        logic [ID_W-1:0] focused_pane;
    } focus_outcome_t;

    // shadow table, centres kept as plain integers
    bit [ID_W-1:0]      pane_ids [MAX_PANES];
    int                 ctr_x    [MAX_PANES];
    int                 ctr_y    [MAX_PANES];
    bit [ID_W-1:0]      focus_id;
    bit [COUNT_W-1:0]   pane_count;
    focus_outcome_t     outcome_q [$];

    task automatic predict_focus_outcome(
        input  op_t                 op,
        input  logic [SLOT_W-1:0]   slot,
        input  logic [ID_W-1:0]     id,
        input  logic signed [15:0]  l,
        input  logic signed [15:0]  t,
        input  logic [SIZE_W-1:0]   w,
        input  logic [SIZE_W-1:0]   h,
        input  dir_t                dir,
        input  logic                fwd,
        output status_t             st
    );
        int  cnt, cur, nxt, best, lowest_score, i;
        int  ox, oy, primary, ortho, metric;
        bit  keep;
        st = STAT_OK;
        case (op)
            OP_WRITE:
            begin
                if (int'(slot) < MAX_PANES)
                begin
                    pane_ids[slot] = id;
                    ctr_x[slot]    = int'(l) + int'(w >> 1);
                    ctr_y[slot]    = int'(t) + int'(h >> 1);
                end
            end
            OP_FOCUS:
            begin
                focus_id = id;
            end
            default:
            begin
                cnt = (int'(pane_count) > MAX_PANES) ? MAX_PANES : int'(pane_count);
                // lowest index holding the focused id
                cur = -1;
                for (i = cnt - 1; i >= 0; i--)
                    if (pane_ids[i] == focus_id)
                        cur = i;
                if (cnt == 0)
                    st = STAT_EMPTY;
                else if (cur < 0)
                    st = STAT_NOT_FOUND;
                else if (op == OP_CYCLE)
                begin
                    if (fwd)
                        nxt = (cur + 1 == cnt) ? 0 : cur + 1;
                    else
                        nxt = (cur == 0) ? cnt - 1 : cur - 1;
                    focus_id = pane_ids[nxt];
                end
                else
                begin
                    best         = -1;
                    lowest_score = 0;
                    for (i = 0; i < cnt; i++)
                    begin
                        ox = ctr_x[i];
                        oy = ctr_y[i];
                        case (dir)
                            DIR_LEFT:
                            begin
                                keep    = ox < ctr_x[cur];
                                primary = ctr_x[cur] - ox;
                                ortho   = oy - ctr_y[cur];
                            end
                            DIR_RIGHT:
                            begin
                                keep    = ox > ctr_x[cur];
                                primary = ox - ctr_x[cur];
                                ortho   = oy - ctr_y[cur];
                            end
                            DIR_UP:
                            begin
                                keep    = oy < ctr_y[cur];
                                primary = ctr_y[cur] - oy;
                                ortho   = ox - ctr_x[cur];
                            end
                            default:
                            begin
                                keep    = oy > ctr_y[cur];
                                primary = oy - ctr_y[cur];
                                ortho   = ox - ctr_x[cur];
                            end
                        endcase
                        if (ortho < 0)
                            ortho = -ortho;
                        metric = primary + 2 * ortho;
                        if (i != cur && keep && (best < 0 || metric < lowest_score))
                        begin
                            best         = i;
                            lowest_score = metric;
                        end
                    end
                    if (best < 0)
                        st = STAT_NO_CAND;
                    else
                        focus_id = pane_ids[best];
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        focus_outcome_t exp_o;
        status_t        st;
        if (!rst_n)
        begin
            focus_id   = '0;
            pane_count = '0;
            outcome_q.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                pane_count = cfg.data;

            if (rsp.valid && rsp.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("response with no request waiting: status %0d focused_pane %0h",
                           rsp.status, rsp.focused_pane);
                    fail_count++;
                end
                else
                begin
                    exp_o = outcome_q.pop_front();
                    if (rsp.status !== exp_o.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_o.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.focused_pane !== exp_o.focused_pane)
                    begin
                        $error("focused_pane: expected %0h, got %0h",
                               exp_o.focused_pane, rsp.focused_pane);
                        fail_count++;
                    end
                end
            end

            if (req.valid && req.ready)
            begin
                predict_focus_outcome(op_t'(req.opcode), req.entry_index, req.pane_id,
                                      req.left, req.top, req.width, req.height,
                                      dir_t'(req.direction), req.forward, st);
                exp_o.status       = st;
                exp_o.focused_pane = focus_id;
                outcome_q.push_back(exp_o);
            end

            pending <= outcome_q.size();
        end
    end

endmodule

`default_nettype wire

### sim/directional_nearest_pane_select_core_tb.sv
`default_nettype none

// stimulus and verdict for the pane select core; all checking is done by
// the checker instance beside the block
module directional_nearest_pane_select_core_tb
    import dnps_pkg::*;
;

    localparam int MAX_PANES    = MAX_PANES_DEF;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 600000;
    // a move over a full table is the slowest request
    localparam int DRAIN_CYCLES = 2 * MAX_PANES + 16;
    localparam int IDLE_PCT     = 18;

    typedef struct {
        op_t                 opcode;
        logic [SLOT_W-1:0]   entry_index;
        logic [ID_W-1:0]     pane_id;
        logic signed [15:0]  left;
        logic signed [15:0]  top;
        logic [SIZE_W-1:0]   width;
        logic [SIZE_W-1:0]   height;
        dir_t                direction;
        logic                forward;
    } pane_req_t;

    logic clk;
    logic rst_n;

    dnps_cfg_if cfg_ch ();
    dnps_req_if req_ch ();
    dnps_rsp_if rsp_ch ();

    int pending;
    int fail_count;
    int cycle_count;
    // no idling on either side while set
    bit calm;

    // what the stimulus knows of the table, only to keep requests well formed
    int            cur_count;
    bit            slot_written [MAX_PANES];
    bit [ID_W-1:0] slot_id      [MAX_PANES];

    directional_nearest_pane_select_core #(
        .MAX_PANES (MAX_PANES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    pane_select_checker #(
        .MAX_PANES (MAX_PANES)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // response side stalls at random, except during the calm stretch
    always @(posedge clk)
        rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    // every field random, so that unused fields toggle as well
    function automatic pane_req_t random_fields();
        pane_req_t r;
        r.opcode      = op_t'($urandom_range(0, 3));
        r.entry_index = SLOT_W'($urandom_range(0, 63));
        r.pane_id     = ID_W'($urandom);
        r.left        = 16'($urandom);
        r.top         = 16'($urandom);
        r.width       = SIZE_W'($urandom);
        r.height      = SIZE_W'($urandom);
        r.direction   = dir_t'($urandom_range(0, 3));
        r.forward     = 1'($urandom);
        return r;
    endfunction

    function automatic pane_req_t write_req(input int slot, input bit [15:0] id,
                                            input int l, input int t,
                                            input int w, input int h);
        pane_req_t r;
        r             = random_fields();
        r.opcode      = OP_WRITE;
        r.entry_index = SLOT_W'(slot);
        r.pane_id     = id;
        r.left        = 16'(l);
        r.top         = 16'(t);
        r.width       = SIZE_W'(w);
        r.height      = SIZE_W'(h);
        return r;
    endfunction

    function automatic pane_req_t focus_req(input bit [15:0] id);
        pane_req_t r;
        r         = random_fields();
        r.opcode  = OP_FOCUS;
        r.pane_id = id;
        return r;
    endfunction

    function automatic pane_req_t move_req(input dir_t d);
        pane_req_t r;
        r           = random_fields();
        r.opcode    = OP_MOVE;
        r.direction = d;
        return r;
    endfunction

    function automatic pane_req_t cycle_req(input bit fwd);
        pane_req_t r;
        r         = random_fields();
        r.opcode  = OP_CYCLE;
        r.forward = fwd;
        return r;
    endfunction

    // mostly a small pool of ids so that duplicates and hits are common
    function automatic bit [15:0] pick_id();
        if ($urandom_range(0, 99) < 70)
            return 16'($urandom_range(1, 8));
        return 16'($urandom);
    endfunction

    // mostly a coarse grid near the origin so that ties and near misses occur
    function automatic int pick_coord();
        if ($urandom_range(0, 99) < 75)
            return int'($urandom_range(0, 20)) * 10 - 100;
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int pick_size();
        if ($urandom_range(0, 99) < 75)
            return int'($urandom_range(0, 40));
        return int'($urandom_range(0, 32767));
    endfunction

    function automatic pane_req_t next_random_request();
        pane_req_t r;
        int        eff, gap, pick, i, slot;
        eff = (cur_count > MAX_PANES) ? MAX_PANES : cur_count;
        // lowest slot in use that has not been written yet
        gap = -1;
        for (i = eff - 1; i >= 0; i--)
            if (!slot_written[i])
                gap = i;
        pick = $urandom_range(0, 99);
        if (pick < 30 || (pick >= 50 && gap >= 0))
        begin
            // a move or cycle would read an unwritten slot, so fill it first
            slot = (pick >= 50) ? gap : int'($urandom_range(0, 63));
            r = write_req(slot, pick_id(), pick_coord(), pick_coord(),
                          pick_size(), pick_size());
        end
        else if (pick < 50)
        begin
            if (eff > 0 && $urandom_range(0, 99) < 75)
                r = focus_req(slot_id[$urandom_range(0, eff - 1)]);
            else
                r = focus_req(pick_id());
        end
        else if (pick < 85)
            r = move_req(dir_t'($urandom_range(0, 3)));
        else
            r = cycle_req(1'($urandom));
        return r;
    endfunction

    // presents one request, with random idle cycles in front, and returns at
    // the edge where it is taken; valid stays high for a following request
    task automatic issue_request(input pane_req_t r);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= r.opcode;
        req_ch.entry_index <= r.entry_index;
        req_ch.pane_id     <= r.pane_id;
        req_ch.left        <= r.left;
        req_ch.top         <= r.top;
        req_ch.width       <= r.width;
        req_ch.height      <= r.height;
        req_ch.direction   <= r.direction;
        req_ch.forward     <= r.forward;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (r.opcode == OP_WRITE)
        begin
            slot_written[r.entry_index] = 1'b1;
            slot_id[r.entry_index]      = r.pane_id;
        end
    endtask

    // drop valid and wait for every outstanding response
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // pane count is only written while the block is idle
    task automatic write_pane_count(input int n);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= COUNT_W'(n);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        cur_count = n;
    endtask

    initial
    begin
        int done_items;
        int phase;
        int n;
        int len;
        int k;
        int r;

        rst_n              <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.data        <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.opcode      <= '0;
        req_ch.entry_index <= '0;
        req_ch.pane_id     <= '0;
        req_ch.left        <= '0;
        req_ch.top         <= '0;
        req_ch.width       <= '0;
        req_ch.height      <= '0;
        req_ch.direction   <= '0;
        req_ch.forward     <= 1'b0;
        calm               = 1'b0;
        cur_count          = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // pane count is zero after reset: move and cycle report an empty table
        issue_request(move_req(DIR_LEFT));
        issue_request(cycle_req(1'b1));

        // extreme rectangles: most negative corner with largest size, most
        // positive corner with zero size, an odd width halved by truncation
        issue_request(write_req(0, 16'h0001, -32768, -32768, 32767, 32767));
        issue_request(write_req(1, 16'hFFFF, 32767, 32767, 0, 0));
        issue_request(write_req(2, 16'h1234, 0, 0, 100, 100));
        issue_request(write_req(3, 16'h8000, 1000, 0, 1, 1));
        issue_request(write_req(63, 16'h5A5A, -1, 1, 16383, 3));

        settle();
        write_pane_count(4);

        // moves in all four directions, including one with nothing on that side
        issue_request(focus_req(16'h1234));
        issue_request(move_req(DIR_RIGHT));
        issue_request(move_req(DIR_UP));
        issue_request(move_req(DIR_UP));
        issue_request(move_req(DIR_DOWN));
        issue_request(move_req(DIR_LEFT));

        // cycle wraps at both ends of the table
        issue_request(focus_req(16'h8000));
        issue_request(cycle_req(1'b1));
        issue_request(focus_req(16'h0001));
        issue_request(cycle_req(1'b0));

        // focused id absent from the table: focus stays as it was
        issue_request(focus_req(16'hBEEF));
        issue_request(move_req(DIR_DOWN));
        issue_request(cycle_req(1'b1));

        // ---- random part ----
        // phases of random length, each with its own pane count; the first
        // ones take the largest count, zero and exactly the table size
        done_items = 0;
        phase      = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            settle();
            case (phase)
                0:       n = 127;
                1:       n = 0;
                2:       n = MAX_PANES;
                default:
                begin
                    r = $urandom_range(0, 99);
                    if (r < 5)
                        n = 0;
                    else if (r < 12)
                        n = MAX_PANES;
                    else if (r < 20)
                        n = $urandom_range(MAX_PANES + 1, 127);
                    else if (r < 32)
                        n = $urandom_range(9, MAX_PANES - 1);
                    else
                        n = $urandom_range(1, 8);
                end
            endcase
            write_pane_count(n);
            len = $urandom_range(20, 60);
            for (k = 0; k < len && done_items < RANDOM_ITEMS; k++)
            begin
                // a long stretch at full rate on both sides
                calm = (done_items >= 150 && done_items < 260);
                issue_request(next_random_request());
                done_items++;
            end
            phase++;
        end
        calm = 1'b0;

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

### directional_nearest_pane_select_core.f
design/dnps_pkg.sv
design/dnps_if.sv
design/dnps_scan_unit.sv
design/directional_nearest_pane_select_core.sv
sim/directional_nearest_pane_select_core_checker.sv
sim/directional_nearest_pane_select_core_tb.sv
